// ===== rtl/core/pedal_event_queue_core_assert.svh =====
// Assertion macros of the pedal event queue, included by the event ring.
`ifndef PEDAL_EVENT_QUEUE_CORE_ASSERT_SVH
`define PEDAL_EVENT_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define PEQ_ASSERT_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define PEQ_ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/core/peq_pkg.sv =====
// Types, codes and constants of the pedal event queue.
package peq_pkg;

  localparam int PEQ_NUM_PEDALS  = 5;
  localparam int PEQ_QUEUE_DEPTH = 16;

  localparam int CMD_W    = 2;
  localparam int STATES_W = 5;
  localparam int BANK_W   = 2;
  localparam int PAD_W    = 4;
  localparam int LEVEL_W  = 5;

  localparam logic [CMD_W-1:0] CMD_SCAN = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BANK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;

  localparam logic [BANK_W-1:0] LAST_BANK   = 2'd2;
  localparam logic [PAD_W-1:0]  BANK_STRIDE = 4'd5;

  typedef struct packed {
    logic             pressed;
    logic [PAD_W-1:0] pad;
  } peq_entry_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    peq_entry_t wr_entry;
  } peq_ring_ctl_t;

  typedef struct packed {
    logic               event_valid;
    logic [PAD_W-1:0]   event_pad;
    logic               event_pressed;
    logic [LEVEL_W-1:0] queue_level;
  } peq_result_t;

  // First pad number of a bank, wrapped to the pad width.
  function automatic logic [PAD_W-1:0] bank_base(input logic [BANK_W-1:0] bank);
    logic [PAD_W-1:0] b;
    b = PAD_W'(bank);
    return PAD_W'(b * BANK_STRIDE);
  endfunction

endpackage

// ===== rtl/core/peq_if.sv =====
// Request and response channels of the pedal event queue.
interface peq_req_if import peq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [STATES_W-1:0] pedal_states;
  logic [BANK_W-1:0]   bank;

  modport source(output valid, command, pedal_states, bank, input ready);
  modport sink(input valid, command, pedal_states, bank, output ready);
endinterface

interface peq_rsp_if import peq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               event_valid;
  logic [PAD_W-1:0]   event_pad;
  logic               event_pressed;
  logic [LEVEL_W-1:0] queue_level;

  modport source(output valid, event_valid, event_pad, event_pressed, queue_level,
                 input ready);
  modport sink(input valid, event_valid, event_pad, event_pressed, queue_level,
               output ready);
endinterface

// ===== rtl/core/peq_ring.sv =====
// Event ring: two-port memory with head pointer and fill count, full push drops oldest.
module peq_ring import peq_pkg::*; #(
  parameter int QUEUE_DEPTH = PEQ_QUEUE_DEPTH,
  localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  peq_ring_ctl_t ctl,
  output logic [CW-1:0] count,
  output peq_entry_t    rd_entry
);

  peq_entry_t mem [QUEUE_DEPTH];

  logic [HW-1:0] head;
  logic [HW-1:0] head_inc;
  logic [HW-1:0] wr_addr;
  logic [CW:0]   tail_sum;
  logic          full;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
  assign tail_sum = (CW + 1)'(head) + (CW + 1)'(count);

  // Tail slot; on a full ring it is the oldest slot, which gets overwritten.
  always_comb begin
    if (full) begin
      wr_addr = head;
    end else if (tail_sum >= (CW + 1)'(QUEUE_DEPTH)) begin
      wr_addr = HW'(tail_sum - (CW + 1)'(QUEUE_DEPTH));
    end else begin
      wr_addr = HW'(tail_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= ctl.wr_entry;
    end
    if (ctl.pop) begin
      rd_entry <= mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.push) begin
      if (full) begin
        head <= head_inc;
      end else begin
        count <= count + CW'(1);
      end
    end else if (ctl.pop) begin
      head  <= head_inc;
      count <= count - CW'(1);
    end
  end

`include "pedal_event_queue_core_assert.svh"

  `PEQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(QUEUE_DEPTH), "ring count above depth")
  `PEQ_ASSERT_NOW(a_pop_nonempty, ctl.pop, count != '0 && !ctl.push, "pop on empty ring or with push")
  `PEQ_ASSERT_NEXT(a_full_stays, ctl.push && full, full && head != $past(head), "full push did not drop oldest")

endmodule

// ===== rtl/core/peq_seq.sv =====
// Command sequencer: walks the pedals one per cycle and drives the ring.
module peq_seq import peq_pkg::*; #(
  parameter int NUM_PEDALS = PEQ_NUM_PEDALS,
  parameter int QUEUE_DEPTH = PEQ_QUEUE_DEPTH,
  localparam int IW = (NUM_PEDALS > 1) ? $clog2(NUM_PEDALS) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int EXT_W = (NUM_PEDALS > STATES_W) ? NUM_PEDALS : STATES_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [CMD_W-1:0]    command,
  input  logic [STATES_W-1:0] pedal_states,
  input  logic [BANK_W-1:0]   bank,
  input  logic [CW-1:0]       ring_count,
  input  peq_entry_t          rd_entry,
  input  logic                slot_free,
  output logic                idle,
  output peq_ring_ctl_t       ctl,
  output logic                done,
  output peq_result_t         result
);

  typedef enum logic [1:0] {IDLE, WALK, POP, FINISH} state_t;

  state_t                 state;
  logic [CMD_W-1:0]       cmd;
  logic [NUM_PEDALS-1:0]  states;
  logic [BANK_W-1:0]      bnk;
  logic [IW-1:0]          idx;
  logic [NUM_PEDALS-1:0]  held;
  logic [PAD_W-1:0]       pad_offset;
  logic                   pop_hit;

  logic [EXT_W-1:0] states_ext;
  logic             bit_now;
  logic             bit_was;
  logic             last_pedal;
  logic             is_scan;

  assign states_ext = EXT_W'(pedal_states);
  assign bit_now    = states[idx];
  assign bit_was    = held[idx];
  assign last_pedal = (idx == IW'(NUM_PEDALS - 1));
  assign is_scan    = (cmd == CMD_SCAN);
  assign idle       = (state == IDLE);

  always_comb begin
    ctl                  = '0;
    ctl.wr_entry.pad     = pad_offset + PAD_W'(idx);
    ctl.wr_entry.pressed = is_scan & bit_now;
    if (state == WALK) begin
      ctl.push = is_scan ? (bit_now ^ bit_was) : bit_was;
    end
    if (state == POP) begin
      ctl.pop = (ring_count != '0);
    end
  end

  always_comb begin
    result             = '0;
    result.queue_level = LEVEL_W'(ring_count);
    if (cmd == CMD_POP && pop_hit) begin
      result.event_valid   = 1'b1;
      result.event_pad     = rd_entry.pad;
      result.event_pressed = rd_entry.pressed;
    end
  end

  assign done = (state == FINISH) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      held       <= '0;
      pad_offset <= '0;
      pop_hit    <= 1'b0;
      idx        <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (start) begin
            cmd    <= command;
            states <= states_ext[NUM_PEDALS-1:0];
            bnk    <= bank;
            idx    <= '0;
            case (command)
              CMD_SCAN: state <= WALK;
              CMD_BANK: state <= (bank <= LAST_BANK) ? WALK : FINISH;
              CMD_POP:  state <= POP;
              default:  state <= FINISH;
            endcase
          end
        end
        WALK: begin
          if (last_pedal) begin
            // Commit what the walk leaves behind.
            if (is_scan) begin
              held <= states;
            end else begin
              pad_offset <= bank_base(bnk);
            end
            state <= FINISH;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        POP: begin
          pop_hit <= (ring_count != '0);
          state   <= FINISH;
        end
        FINISH: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/pedal_event_queue_core.sv =====
// Pedal event queue: one command per item, result held in an output register.
// Scan and bank commands walk the pedals one per cycle through the single write port
// of the ring. A new command is accepted only when the sequencer is idle again. The
// result is valid the cycle after the sequencer finishes.
// Reset (rst, synchronous) empties the ring, clears held pedals and sets bank 0;
// ring contents are not cleared.
module pedal_event_queue_core import peq_pkg::*; #(
  parameter int NUM_PEDALS = PEQ_NUM_PEDALS,
  parameter int QUEUE_DEPTH = PEQ_QUEUE_DEPTH,
  localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input logic       clk,
  input logic       rst,
  peq_req_if.sink   req,
  peq_rsp_if.source rsp
);

  peq_ring_ctl_t ctl;
  peq_entry_t    rd_entry;
  peq_result_t   fin;
  peq_result_t   out_data;
  logic [CW-1:0] ring_count;
  logic          seq_idle;
  logic          done;
  logic          out_valid;
  logic          slot_free;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = seq_idle;

  peq_seq #(
    .NUM_PEDALS  (NUM_PEDALS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (req.valid && seq_idle),
    .command      (req.command),
    .pedal_states (req.pedal_states),
    .bank         (req.bank),
    .ring_count   (ring_count),
    .rd_entry     (rd_entry),
    .slot_free    (slot_free),
    .idle         (seq_idle),
    .ctl          (ctl),
    .done         (done),
    .result       (fin)
  );

  peq_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .count    (ring_count),
    .rd_entry (rd_entry)
  );

  // Output register: load a finished item, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data <= fin;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.event_valid   = out_data.event_valid;
  assign rsp.event_pad     = out_data.event_pad;
  assign rsp.event_pressed = out_data.event_pressed;
  assign rsp.queue_level   = out_data.queue_level;

endmodule
